### rtl/core/trial_division_prime_test_core_assert.svh
// Assertion macros shared by the core RTL.
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH

// expr must hold at every clock edge out of reset
`define TDPT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// cond at one edge implies expr at the same edge
`define TDPT_ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// cond at one edge implies expr at the next edge
`define TDPT_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

### rtl/core/tdpt_pkg.sv
package tdpt_pkg;

  // first odd divisor used to reject multiples of three
  localparam int unsigned DIV_THREE = 3;
  // first candidate of the 6k-1 / 6k+1 series and the step between pairs
  localparam int unsigned CAND_START = 5;
  localparam int unsigned CAND_PAIR  = 2;
  localparam int unsigned CAND_STEP  = 6;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/core/trial_division_prime_test_core.sv
// Primality test by trial division over 6k-1 / 6k+1 candidates.
// Input channel: in_valid / in_stall carry in_number (NUM_WIDTH bits).
// Output channel: out_valid / out_stall carry out_prime_flag, one result
// per request, in request order.
// A request is taken only while the core is idle; in_stall stays high
// for the whole test. Values below 2, 2, 3 and even values are settled
// in S_CHK without the divider and go on to S_FIN. Other values run
// their divisions on the one shared restoring divider: one for 3, then
// two per candidate pair (d and d+2) while d <= n/d. A 32-bit prime
// needs about 10923 pairs.
// The result sits in an output register; the next request may be taken
// while it waits. If the receiver stalls and a new result is ready,
// the core holds it and keeps in_stall high until the register frees.
// Reset (synchronous, rst_n low) drops any test in flight and empties
// the output register. Nothing is kept from one request to the next.
`include "trial_division_prime_test_core_assert.svh"

module trial_division_prime_test_core
  import tdpt_pkg::*;
#(
  parameter int NUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [NUM_WIDTH-1:0] in_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_prime_flag
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_DIV3  = 3'd2;
  localparam logic [2:0] S_DIVD  = 3'd3;
  localparam logic [2:0] S_DIVD2 = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [NUM_WIDTH-1:0] n_r;
  logic [NUM_WIDTH-1:0] d_r, d_nxt;
  logic                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_flag_r, out_flag_nxt;
  logic                 div_start;
  logic [NUM_WIDTH-1:0] div_divisor;
  div_stat_t            div_stat;
  logic [NUM_WIDTH-1:0] div_quot;
  logic [NUM_WIDTH-1:0] div_rem;
  logic                 in_take;
  logic                 out_free;
  logic                 rem_zero;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign rem_zero = (div_rem == '0);
  assign in_stall = (state_r != S_IDLE);

  tdpt_divider #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_flag_nxt  = out_flag_r;
    div_start     = 1'b0;
    div_divisor   = NUM_WIDTH'(DIV_THREE);
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (n_r < NUM_WIDTH'(2)) begin
          res_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else if (n_r == NUM_WIDTH'(2) || n_r == NUM_WIDTH'(DIV_THREE)) begin
          res_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (!n_r[0]) begin
          res_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          div_start   = 1'b1;
          div_divisor = NUM_WIDTH'(DIV_THREE);
          state_nxt   = S_DIV3;
        end
      end
      S_DIV3: begin
        if (div_stat.done) begin
          if (rem_zero) begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            d_nxt       = NUM_WIDTH'(CAND_START);
            div_start   = 1'b1;
            div_divisor = NUM_WIDTH'(CAND_START);
            state_nxt   = S_DIVD;
          end
        end
      end
      S_DIVD: begin
        if (div_stat.done) begin
          // loop bound d*d <= n tested as d <= n/d
          if (d_r > div_quot) begin
            res_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else if (rem_zero) begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            div_start   = 1'b1;
            div_divisor = d_r + NUM_WIDTH'(CAND_PAIR);
            state_nxt   = S_DIVD2;
          end
        end
      end
      S_DIVD2: begin
        if (div_stat.done) begin
          if (rem_zero) begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            d_nxt       = d_r + NUM_WIDTH'(CAND_STEP);
            div_start   = 1'b1;
            div_divisor = d_r + NUM_WIDTH'(CAND_STEP);
            state_nxt   = S_DIVD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      n_r <= in_number;
    end
    d_r        <= d_nxt;
    res_r      <= res_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_prime_flag = out_flag_r;

  `TDPT_ASSERT_ALWAYS(a_no_start_busy, clk, rst_n, !(div_start && div_stat.busy),
    "divider restarted while busy")
  `TDPT_ASSERT_IMPLIES(a_done_in_div, clk, rst_n, div_stat.done,
    state_r == S_DIV3 || state_r == S_DIVD || state_r == S_DIVD2,
    "divider result outside a division state")
  `TDPT_ASSERT_NEXT(a_take_to_chk, clk, rst_n, in_take, state_r == S_CHK,
    "accepted request did not start a test")
  `TDPT_ASSERT_IMPLIES(a_out_from_fin, clk, rst_n, $rose(out_valid_r),
    $past(state_r) == S_FIN, "result loaded outside finish state")

endmodule

### rtl/core/tdpt_divider.sv
module tdpt_divider
  import tdpt_pkg::*;
#(
  parameter int NUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [NUM_WIDTH-1:0] divisor,
  output div_stat_t            stat,
  output logic [NUM_WIDTH-1:0] quot,
  output logic [NUM_WIDTH-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] rem_r, rem_nxt;
  logic [NUM_WIDTH-1:0] quo_r, quo_nxt;
  logic [NUM_WIDTH-1:0] dvs_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [NUM_WIDTH:0]   shifted;
  logic [NUM_WIDTH:0]   diff;
  logic                 take;

  // restoring division, one quotient bit a cycle
  always_comb begin
    shifted = {rem_r, quo_r[NUM_WIDTH-1]};
    diff    = shifted - {1'b0, dvs_r};
    take    = ~diff[NUM_WIDTH];
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(NUM_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = take ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
      quo_nxt = {quo_r[NUM_WIDTH-2:0], take};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;
  assign rem       = rem_r;

endmodule
